// File: sv/sfgr_pkg.sv
package sfgr_pkg;

  localparam int SCREEN_WIDTH  = 240;
  localparam int SCREEN_HEIGHT = 240;

  localparam logic [7:0] FirstCode = 8'h20;
  localparam logic [7:0] LastCode  = 8'h7E;
  localparam logic [7:0] MaxScale  = 8'd3;
  localparam logic [2:0] LastCol   = 3'd4;
  localparam logic [2:0] LastRow   = 3'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FORE,
    ST_BACK,
    ST_FLUSH
  } walk_state_e;

  typedef struct packed {
    logic [7:0]  x;
    logic [7:0]  y;
    logic [1:0]  w;
    logic [1:0]  h;
    logic [15:0] color;
  } rect_t;

  typedef struct packed {
    logic  on_screen;
    rect_t rect;
  } clip_t;

  // columns 0..4 from the msb down, bit r of a column byte is row r
  function automatic logic [39:0] glyph_bits(input logic [6:0] idx);
    logic [39:0] g;
    case (idx)
      7'd0:  g = 40'h0000000000;
      7'd1:  g = 40'h00005F0000;
      7'd2:  g = 40'h0007000700;
      7'd3:  g = 40'h147F147F14;
      7'd4:  g = 40'h242A7F2A12;
      7'd5:  g = 40'h2313086462;
      7'd6:  g = 40'h3649552250;
      7'd7:  g = 40'h0005030000;
      7'd8:  g = 40'h001C224100;
      7'd9:  g = 40'h0041221C00;
      7'd10: g = 40'h082A1C2A08;
      7'd11: g = 40'h08083E0808;
      7'd12: g = 40'h0050300000;
      7'd13: g = 40'h0808080808;
      7'd14: g = 40'h0060600000;
      7'd15: g = 40'h2010080402;
      7'd16: g = 40'h3E5149453E;
      7'd17: g = 40'h00427F4000;
      7'd18: g = 40'h4261514946;
      7'd19: g = 40'h2141454B31;
      7'd20: g = 40'h1814127F10;
      7'd21: g = 40'h2745454539;
      7'd22: g = 40'h3C4A494930;
      7'd23: g = 40'h0171090503;
      7'd24: g = 40'h3649494936;
      7'd25: g = 40'h064949291E;
      7'd26: g = 40'h0036360000;
      7'd27: g = 40'h0056360000;
      7'd28: g = 40'h0008142241;
      7'd29: g = 40'h1414141414;
      7'd30: g = 40'h4122140800;
      7'd31: g = 40'h0201510906;
      7'd32: g = 40'h324979413E;
      7'd33: g = 40'h7E1111117E;
      7'd34: g = 40'h7F49494936;
      7'd35: g = 40'h3E41414122;
      7'd36: g = 40'h7F4141221C;
      7'd37: g = 40'h7F49494941;
      7'd38: g = 40'h7F09090101;
      7'd39: g = 40'h3E41415132;
      7'd40: g = 40'h7F0808087F;
      7'd41: g = 40'h00417F4100;
      7'd42: g = 40'h2040413F01;
      7'd43: g = 40'h7F08142241;
      7'd44: g = 40'h7F40404040;
      7'd45: g = 40'h7F0204027F;
      7'd46: g = 40'h7F0408107F;
      7'd47: g = 40'h3E4141413E;
      7'd48: g = 40'h7F09090906;
      7'd49: g = 40'h3E4151215E;
      7'd50: g = 40'h7F09192946;
      7'd51: g = 40'h4649494931;
      7'd52: g = 40'h01017F0101;
      7'd53: g = 40'h3F4040403F;
      7'd54: g = 40'h1F2040201F;
      7'd55: g = 40'h7F2018207F;
      7'd56: g = 40'h6314081463;
      7'd57: g = 40'h0304780403;
      7'd58: g = 40'h6151494543;
      7'd59: g = 40'h00007F4141;
      7'd60: g = 40'h0204081020;
      7'd61: g = 40'h41417F0000;
      7'd62: g = 40'h0402010204;
      7'd63: g = 40'h4040404040;
      7'd64: g = 40'h0001020400;
      7'd65: g = 40'h2054545478;
      7'd66: g = 40'h7F48444438;
      7'd67: g = 40'h3844444420;
      7'd68: g = 40'h384444487F;
      7'd69: g = 40'h3854545418;
      7'd70: g = 40'h087E090102;
      7'd71: g = 40'h081454543C;
      7'd72: g = 40'h7F08040478;
      7'd73: g = 40'h00447D4000;
      7'd74: g = 40'h2040443D00;
      7'd75: g = 40'h007F102844;
      7'd76: g = 40'h00417F4000;
      7'd77: g = 40'h7C04180478;
      7'd78: g = 40'h7C08040478;
      7'd79: g = 40'h3844444438;
      7'd80: g = 40'h7C14141408;
      7'd81: g = 40'h081414187C;
      7'd82: g = 40'h7C08040408;
      7'd83: g = 40'h4854545420;
      7'd84: g = 40'h043F444020;
      7'd85: g = 40'h3C4040207C;
      7'd86: g = 40'h1C2040201C;
      7'd87: g = 40'h3C4030403C;
      7'd88: g = 40'h4428102844;
      7'd89: g = 40'h0C5050503C;
      7'd90: g = 40'h4464544C44;
      7'd91: g = 40'h0008364100;
      7'd92: g = 40'h00007F0000;
      7'd93: g = 40'h0041360800;
      7'd94: g = 40'h08082A1C08;
      default: g = 40'h0000000000;
    endcase
    return g;
  endfunction

endpackage

// File: sv/scaled_font_glyph_renderer_top.sv
// channel | valid      | stall       | payload
// input   | in_valid_i | in_stall_o  | char_code_i start_of_string_i start_column_i
//         |            |             | text_row_i fore_color_i back_color_i scale_i
// output  | out_valid_o| out_stall_i | rect_x_o rect_y_o rect_w_o rect_h_o
//         |            |             | rect_color_o last_o
// one glyph bit is examined per cycle unless the walk pauses: the foreground pass, then the
// background pass at scale 2 or 3 with differing colors, then the flush state.
// a character outside 0x20..0x7e is accepted without leaving idle and yields no word.
// in_stall_o is high from acceptance until the last word has entered the output register.
// one rectangle is held back so that the final one can be tagged; the walk pauses
// while a new rectangle, the held one and a stalled output register all collide.
// rst_ni clears the cursor and all valid flags.
module scaled_font_glyph_renderer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_code_i,
  input  logic        start_of_string_i,
  input  logic [15:0] start_column_i,
  input  logic [15:0] text_row_i,
  input  logic [15:0] fore_color_i,
  input  logic [15:0] back_color_i,
  input  logic [7:0]  scale_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  rect_x_o,
  output logic [7:0]  rect_y_o,
  output logic [1:0]  rect_w_o,
  output logic [1:0]  rect_h_o,
  output logic [15:0] rect_color_o,
  output logic        last_o
);
  import sfgr_pkg::*;

  walk_state_e state_q, state_d;

  logic [15:0] cursor_q;
  logic        hold_vld_q, hold_vld_d;
  logic        out_vld_q, out_vld_d;
  rect_t       hold_q, hold_d;
  rect_t       out_q, out_d;
  logic        last_q, last_d;

  logic [39:0] glyph_q;
  logic [1:0]  scale_q;
  logic [15:0] fore_q, back_q, row0_q, base_q;
  logic [15:0] x_q, y_q;
  logic [2:0]  col_q, row_q;
  logic        diff_q;

  logic        accept;
  logic        printable;
  logic [1:0]  scale_in;
  logic [15:0] base_in;
  logic [4:0]  advance;
  logic [2:0]  col_rev;
  logic        bit_on;
  logic        want;
  logic [15:0] color;
  logic        walking;
  logic        out_free;
  logic        cand_vld;
  logic        blocked;
  logic        step;
  logic        push_hold;
  logic        wrap;
  clip_t       clip;

  assign printable = (char_code_i >= FirstCode) && (char_code_i <= LastCode);
  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign base_in   = start_of_string_i ? start_column_i : cursor_q;

  always_comb begin
    if (scale_i == 8'd0) begin
      scale_in = 2'd1;
    end else if (scale_i > MaxScale) begin
      scale_in = MaxScale[1:0];
    end else begin
      scale_in = scale_i[1:0];
    end
  end

  // six times the scale, as 4s + 2s
  assign advance = 5'({scale_in, 2'b00}) + 5'({scale_in, 1'b0});

  assign col_rev = 3'(LastCol - col_q);
  assign bit_on  = glyph_q[{col_rev, row_q}];
  assign walking = (state_q == ST_FORE) || (state_q == ST_BACK);
  assign wrap    = (col_q == LastCol) && (row_q == LastRow);

  always_comb begin
    if (state_q == ST_BACK) begin
      want  = !bit_on;
      color = back_q;
    end else begin
      want  = bit_on || (diff_q && (scale_q == 2'd1));
      color = bit_on ? fore_q : back_q;
    end
  end

  sfgr_clip u_clip (
    .x_i     (x_q),
    .y_i     (y_q),
    .side_i  (scale_q),
    .color_i (color),
    .clip_o  (clip)
  );

  assign out_free = !out_vld_q || !out_stall_i;
  assign cand_vld = walking && want && clip.on_screen;
  assign blocked  = cand_vld && hold_vld_q && !out_free;
  assign step     = walking && !blocked;
  assign push_hold = hold_vld_q && out_free && (cand_vld || (state_q == ST_FLUSH));

  always_comb begin
    state_d    = state_q;
    hold_d     = hold_q;
    hold_vld_d = hold_vld_q;
    out_d      = out_q;
    last_d     = last_q;
    out_vld_d  = out_vld_q && out_stall_i;

    if (push_hold) begin
      out_d     = hold_q;
      last_d    = (state_q == ST_FLUSH);
      out_vld_d = 1'b1;
    end

    if (cand_vld && !blocked) begin
      hold_d     = clip.rect;
      hold_vld_d = 1'b1;
    end else if (push_hold) begin
      hold_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept && printable) begin
          state_d = ST_FORE;
        end
      end
      ST_FORE: begin
        if (step && wrap) begin
          state_d = (diff_q && (scale_q != 2'd1)) ? ST_BACK : ST_FLUSH;
        end
      end
      ST_BACK: begin
        if (step && wrap) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!hold_vld_q || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      cursor_q   <= 16'd0;
    end else begin
      state_q    <= state_d;
      hold_vld_q <= hold_vld_d;
      out_vld_q  <= out_vld_d;
      if (accept) begin
        cursor_q <= printable ? base_in + 16'(advance) : base_in;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    out_q  <= out_d;
    last_q <= last_d;
    if (accept) begin
      glyph_q <= glyph_bits(7'(char_code_i - FirstCode));
      scale_q <= scale_in;
      fore_q  <= fore_color_i;
      back_q  <= back_color_i;
      row0_q  <= text_row_i;
      base_q  <= base_in;
      diff_q  <= (fore_color_i != back_color_i);
      x_q     <= base_in;
      y_q     <= text_row_i;
      col_q   <= 3'd0;
      row_q   <= 3'd0;
    end else if (step) begin
      if (state_q == ST_FORE) begin
        // column major: rows within each column
        if (wrap) begin
          col_q <= 3'd0;
          row_q <= 3'd0;
          x_q   <= base_q;
          y_q   <= row0_q;
        end else if (row_q == LastRow) begin
          row_q <= 3'd0;
          col_q <= col_q + 3'd1;
          y_q   <= row0_q;
          x_q   <= x_q + {14'd0, scale_q};
        end else begin
          row_q <= row_q + 3'd1;
          y_q   <= y_q + {14'd0, scale_q};
        end
      end else begin
        // row major for the background pass
        if (col_q == LastCol) begin
          col_q <= 3'd0;
          row_q <= row_q + 3'd1;
          x_q   <= base_q;
          y_q   <= y_q + {14'd0, scale_q};
        end else begin
          col_q <= col_q + 3'd1;
          x_q   <= x_q + {14'd0, scale_q};
        end
      end
    end
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_vld_q;
  assign rect_x_o     = out_q.x;
  assign rect_y_o     = out_q.y;
  assign rect_w_o     = out_q.w;
  assign rect_h_o     = out_q.h;
  assign rect_color_o = out_q.color;
  assign last_o       = last_q;

endmodule

// File: sv/sfgr_clip.sv
module sfgr_clip (
  input  logic [15:0]          x_i,
  input  logic [15:0]          y_i,
  input  logic [1:0]           side_i,
  input  logic [15:0]          color_i,
  output sfgr_pkg::clip_t      clip_o
);
  import sfgr_pkg::*;

  localparam logic [15:0] ScreenW = 16'(SCREEN_WIDTH);
  localparam logic [15:0] ScreenH = 16'(SCREEN_HEIGHT);

  logic [15:0] room_x;
  logic [15:0] room_y;
  logic [15:0] side_wide;

  assign side_wide = {14'd0, side_i};
  assign room_x    = ScreenW - x_i;
  assign room_y    = ScreenH - y_i;

  always_comb begin
    clip_o.on_screen  = (x_i < ScreenW) && (y_i < ScreenH);
    clip_o.rect.x     = x_i[7:0];
    clip_o.rect.y     = y_i[7:0];
    // cut the square where it runs past the right or bottom edge
    clip_o.rect.w     = (room_x < side_wide) ? room_x[1:0] : side_i;
    clip_o.rect.h     = (room_y < side_wide) ? room_y[1:0] : side_i;
    clip_o.rect.color = color_i;
  end

endmodule

// File: sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sfgr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_CHARS = 106;
  localparam int QUIET_FROM = 85;
  localparam int LONG_HOLD = 400;
  localparam int SETTLE_CYCLES = 200;

  // columns 0..4 of each glyph, bit r is row r
  localparam logic [7:0] FONT_COLS [95][5] = '{
    '{'h00,'h00,'h00,'h00,'h00}, '{'h00,'h00,'h5F,'h00,'h00}, '{'h00,'h07,'h00,'h07,'h00},
    '{'h14,'h7F,'h14,'h7F,'h14}, '{'h24,'h2A,'h7F,'h2A,'h12}, '{'h23,'h13,'h08,'h64,'h62},
    '{'h36,'h49,'h55,'h22,'h50}, '{'h00,'h05,'h03,'h00,'h00}, '{'h00,'h1C,'h22,'h41,'h00},
    '{'h00,'h41,'h22,'h1C,'h00}, '{'h08,'h2A,'h1C,'h2A,'h08}, '{'h08,'h08,'h3E,'h08,'h08},
    '{'h00,'h50,'h30,'h00,'h00}, '{'h08,'h08,'h08,'h08,'h08}, '{'h00,'h60,'h60,'h00,'h00},
    '{'h20,'h10,'h08,'h04,'h02}, '{'h3E,'h51,'h49,'h45,'h3E}, '{'h00,'h42,'h7F,'h40,'h00},
    '{'h42,'h61,'h51,'h49,'h46}, '{'h21,'h41,'h45,'h4B,'h31}, '{'h18,'h14,'h12,'h7F,'h10},
    '{'h27,'h45,'h45,'h45,'h39}, '{'h3C,'h4A,'h49,'h49,'h30}, '{'h01,'h71,'h09,'h05,'h03},
    '{'h36,'h49,'h49,'h49,'h36}, '{'h06,'h49,'h49,'h29,'h1E}, '{'h00,'h36,'h36,'h00,'h00},
    '{'h00,'h56,'h36,'h00,'h00}, '{'h00,'h08,'h14,'h22,'h41}, '{'h14,'h14,'h14,'h14,'h14},
    '{'h41,'h22,'h14,'h08,'h00}, '{'h02,'h01,'h51,'h09,'h06}, '{'h32,'h49,'h79,'h41,'h3E},
    '{'h7E,'h11,'h11,'h11,'h7E}, '{'h7F,'h49,'h49,'h49,'h36}, '{'h3E,'h41,'h41,'h41,'h22},
    '{'h7F,'h41,'h41,'h22,'h1C}, '{'h7F,'h49,'h49,'h49,'h41}, '{'h7F,'h09,'h09,'h01,'h01},
    '{'h3E,'h41,'h41,'h51,'h32}, '{'h7F,'h08,'h08,'h08,'h7F}, '{'h00,'h41,'h7F,'h41,'h00},
    '{'h20,'h40,'h41,'h3F,'h01}, '{'h7F,'h08,'h14,'h22,'h41}, '{'h7F,'h40,'h40,'h40,'h40},
    '{'h7F,'h02,'h04,'h02,'h7F}, '{'h7F,'h04,'h08,'h10,'h7F}, '{'h3E,'h41,'h41,'h41,'h3E},
    '{'h7F,'h09,'h09,'h09,'h06}, '{'h3E,'h41,'h51,'h21,'h5E}, '{'h7F,'h09,'h19,'h29,'h46},
    '{'h46,'h49,'h49,'h49,'h31}, '{'h01,'h01,'h7F,'h01,'h01}, '{'h3F,'h40,'h40,'h40,'h3F},
    '{'h1F,'h20,'h40,'h20,'h1F}, '{'h7F,'h20,'h18,'h20,'h7F}, '{'h63,'h14,'h08,'h14,'h63},
    '{'h03,'h04,'h78,'h04,'h03}, '{'h61,'h51,'h49,'h45,'h43}, '{'h00,'h00,'h7F,'h41,'h41},
    '{'h02,'h04,'h08,'h10,'h20}, '{'h41,'h41,'h7F,'h00,'h00}, '{'h04,'h02,'h01,'h02,'h04},
    '{'h40,'h40,'h40,'h40,'h40}, '{'h00,'h01,'h02,'h04,'h00}, '{'h20,'h54,'h54,'h54,'h78},
    '{'h7F,'h48,'h44,'h44,'h38}, '{'h38,'h44,'h44,'h44,'h20}, '{'h38,'h44,'h44,'h48,'h7F},
    '{'h38,'h54,'h54,'h54,'h18}, '{'h08,'h7E,'h09,'h01,'h02}, '{'h08,'h14,'h54,'h54,'h3C},
    '{'h7F,'h08,'h04,'h04,'h78}, '{'h00,'h44,'h7D,'h40,'h00}, '{'h20,'h40,'h44,'h3D,'h00},
    '{'h00,'h7F,'h10,'h28,'h44}, '{'h00,'h41,'h7F,'h40,'h00}, '{'h7C,'h04,'h18,'h04,'h78},
    '{'h7C,'h08,'h04,'h04,'h78}, '{'h38,'h44,'h44,'h44,'h38}, '{'h7C,'h14,'h14,'h14,'h08},
    '{'h08,'h14,'h14,'h18,'h7C}, '{'h7C,'h08,'h04,'h04,'h08}, '{'h48,'h54,'h54,'h54,'h20},
    '{'h04,'h3F,'h44,'h40,'h20}, '{'h3C,'h40,'h40,'h20,'h7C}, '{'h1C,'h20,'h40,'h20,'h1C},
    '{'h3C,'h40,'h30,'h40,'h3C}, '{'h44,'h28,'h10,'h28,'h44}, '{'h0C,'h50,'h50,'h50,'h3C},
    '{'h44,'h64,'h54,'h4C,'h44}, '{'h00,'h08,'h36,'h41,'h00}, '{'h00,'h00,'h7F,'h00,'h00},
    '{'h00,'h41,'h36,'h08,'h00}, '{'h08,'h08,'h2A,'h1C,'h08}
  };

  typedef struct packed {
    logic [7:0]  char_code;
    logic        start_of_string;
    logic [15:0] start_column;
    logic [15:0] text_row;
    logic [15:0] fore_color;
    logic [15:0] back_color;
    logic [7:0]  scale;
  } char_item_t;

  typedef struct packed {
    rect_t rect;
    logic  last;
  } tile_t;

  class glyph_scoreboard;
    logic [15:0] cursor = '0;
    tile_t pending_rects[$];
    int chars_noted = 0;
    int mismatches = 0;

    function void add_square(int x, int y, int side, logic [15:0] color);
      tile_t t;
      int w;
      int h;
      x = x & 'hFFFF;
      y = y & 'hFFFF;
      if (x >= SCREEN_WIDTH || y >= SCREEN_HEIGHT) return;
      w = (x + side > SCREEN_WIDTH) ? SCREEN_WIDTH - x : side;
      h = (y + side > SCREEN_HEIGHT) ? SCREEN_HEIGHT - y : side;
      t.rect.x = 8'(x);
      t.rect.y = 8'(y);
      t.rect.w = 2'(w);
      t.rect.h = 2'(h);
      t.rect.color = color;
      t.last = 1'b0;
      pending_rects.push_back(t);
    endfunction

    function void note_char(char_item_t it);
      logic [15:0] cx;
      logic [7:0] col;
      int s;
      int first;
      chars_noted++;
      if (it.start_of_string) cursor = it.start_column;
      if (it.char_code < FirstCode || it.char_code > LastCode) return;
      s = (it.scale == 0) ? 1 : (it.scale > MaxScale) ? int'(MaxScale) : int'(it.scale);
      cx = cursor;
      first = pending_rects.size();
      for (int c = 0; c < 5; c++) begin
        col = FONT_COLS[it.char_code - FirstCode][c];
        for (int r = 0; r < 8; r++) begin
          if (col[r]) begin
            add_square(int'(cx) + c * s, int'(it.text_row) + r * s, s, it.fore_color);
          end else if (it.back_color != it.fore_color && s == 1) begin
            add_square(int'(cx) + c, int'(it.text_row) + r, 1, it.back_color);
          end
        end
      end
      // background squares above scale one go row by row in a second pass
      if (it.back_color != it.fore_color && s > 1) begin
        for (int r = 0; r < 8; r++) begin
          for (int c = 0; c < 5; c++) begin
            if (!FONT_COLS[it.char_code - FirstCode][c][r]) begin
              add_square(int'(cx) + c * s, int'(it.text_row) + r * s, s, it.back_color);
            end
          end
        end
      end
      if (pending_rects.size() > first) pending_rects[pending_rects.size() - 1].last = 1'b1;
      cursor = cx + 16'(6 * s);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        mismatches++;
        $error("%s expected %0d got %0d", name, want, got);
      end
    endfunction

    function void check_rect(tile_t got);
      tile_t want;
      if (pending_rects.size() == 0) begin
        mismatches++;
        $error("unexpected word: x %0d y %0d color %h", got.rect.x, got.rect.y, got.rect.color);
        return;
      end
      want = pending_rects.pop_front();
      compare_field("rect_x", 16'(want.rect.x), 16'(got.rect.x));
      compare_field("rect_y", 16'(want.rect.y), 16'(got.rect.y));
      compare_field("rect_w", 16'(want.rect.w), 16'(got.rect.w));
      compare_field("rect_h", 16'(want.rect.h), 16'(got.rect.h));
      compare_field("rect_color", want.rect.color, got.rect.color);
      compare_field("last", 16'(want.last), 16'(got.last));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  char_code_i = '0;
  logic        start_of_string_i = 1'b0;
  logic [15:0] start_column_i = '0;
  logic [15:0] text_row_i = '0;
  logic [15:0] fore_color_i = '0;
  logic [15:0] back_color_i = '0;
  logic [7:0]  scale_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  rect_x_o;
  logic [7:0]  rect_y_o;
  logic [1:0]  rect_w_o;
  logic [1:0]  rect_h_o;
  logic [15:0] rect_color_o;
  logic        last_o;

  glyph_scoreboard sb = new();
  bit idle_on = 1'b1;
  int cycle_count = 0;

  scaled_font_glyph_renderer_top u_dut (.*);

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("scaled_font_glyph_renderer_top verification failed");
      $finish;
    end
  end

  function automatic char_item_t make_char(logic [7:0] code, logic sos, logic [15:0] col,
                                           logic [15:0] row, logic [15:0] fg, logic [15:0] bg,
                                           logic [7:0] scale);
    char_item_t it;
    it.char_code = code;
    it.start_of_string = sos;
    it.start_column = col;
    it.text_row = row;
    it.fore_color = fg;
    it.back_color = bg;
    it.scale = scale;
    return it;
  endfunction

  // holds the word until taken; while idle_on, a random gap may first drop valid
  task automatic send_char(char_item_t it);
    int gap;
    gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 18) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    char_code_i <= it.char_code;
    start_of_string_i <= it.start_of_string;
    start_column_i <= it.start_column;
    text_row_i <= it.text_row;
    fore_color_i <= it.fore_color;
    back_color_i <= it.back_color;
    scale_i <= it.scale;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_char(it);
  endtask

  initial begin : rect_sink
    int stall_left;
    bit held;
    stall_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        sb.check_rect(tile_t'({rect_x_o, rect_y_o, rect_w_o, rect_h_o, rect_color_o, last_o}));
      end
      // one long hold-off so the block backs up into its input
      if (!held && sb.chars_noted >= 30) begin
        held = 1'b1;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 18);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : char_source
    char_item_t it;
    int pick;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_char(make_char(8'h20, 1'b1, 16'd0, 16'd0, 16'hF800, 16'h001F, 8'd1));
    send_char(make_char(8'h30, 1'b0, 16'd0, 16'd8, 16'hFFFF, 16'h0000, 8'd0));
    send_char(make_char(8'h41, 1'b1, 16'd20, 16'd20, 16'h07E0, 16'h0000, 8'd2));
    send_char(make_char(8'h41, 1'b0, 16'd0, 16'd40, 16'h1234, 16'h1234, 8'd3));
    send_char(make_char(8'h7E, 1'b0, 16'd0, 16'd60, 16'hABCD, 16'h5432, 8'hFF));
    // skipped codes still load the cursor
    send_char(make_char(8'h1F, 1'b1, 16'd100, 16'd0, 16'h1111, 16'h2222, 8'd1));
    send_char(make_char(8'h21, 1'b0, 16'd0, 16'd100, 16'hFFFF, 16'h0001, 8'd1));
    send_char(make_char(8'h7F, 1'b1, 16'd200, 16'd0, 16'h1111, 16'h2222, 8'd2));
    send_char(make_char(8'h00, 1'b0, 16'd0, 16'd0, 16'h1111, 16'h2222, 8'd3));
    send_char(make_char(8'hFF, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 8'hFF));
    send_char(make_char(8'h80, 1'b0, 16'd0, 16'd0, 16'h0000, 16'hFFFF, 8'd1));
    // clipping at the right and bottom edges
    send_char(make_char(8'h57, 1'b1, 16'd236, 16'd236, 16'hF0F0, 16'h0F0F, 8'd3));
    send_char(make_char(8'h4D, 1'b1, 16'd239, 16'd239, 16'h00FF, 16'hFF00, 8'd2));
    send_char(make_char(8'h42, 1'b1, 16'hFFFE, 16'hFFFF, 16'h8001, 16'h7FFE, 8'd2));
    send_char(make_char(8'h42, 1'b1, 16'hFFFE, 16'hFFFF, 16'h8001, 16'h7FFE, 8'd1));
    // wholly off screen, the cursor still moves
    send_char(make_char(8'h38, 1'b1, 16'd1000, 16'd0, 16'h1234, 16'h4321, 8'd1));
    send_char(make_char(8'h38, 1'b1, 16'd0, 16'd500, 16'h1234, 16'h4321, 8'd2));
    send_char(make_char(8'h5A, 1'b1, 16'hFFFC, 16'd0, 16'hAAAA, 16'h5555, 8'd1));
    send_char(make_char(8'h5A, 1'b0, 16'd0, 16'd0, 16'hAAAA, 16'h5555, 8'd1));
    send_char(make_char(8'h7B, 1'b0, 16'd0, 16'd0, 16'h0000, 16'hFFFF, 8'd4));
    send_char(make_char(8'h62, 1'b1, 16'd120, 16'd120, 16'hFFFF, 16'hFFFF, 8'd1));
    send_char(make_char(8'h23, 1'b1, 16'd50, 16'd200, 16'h3C3C, 16'hC3C3, 8'h80));
    send_char(make_char(8'h20, 1'b1, 16'd10, 16'd10, 16'h0F0F, 16'h0F0F, 8'd2));
    send_char(make_char(8'h40, 1'b0, 16'd0, 16'd10, 16'h0F0F, 16'h0F0F, 8'd2));

    for (int i = 0; i < RANDOM_CHARS; i++) begin
      if (i == QUIET_FROM) idle_on = 1'b0;
      pick = $urandom_range(0, 19);
      it.char_code = (pick == 0) ? 8'($urandom_range(0, 255)) :
                     (pick == 1) ? 8'($urandom_range(0, 31)) : 8'($urandom_range(32, 126));
      it.start_of_string = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      it.start_column = (pick == 0) ? 16'($urandom) :
                        (pick == 1) ? 16'($urandom_range(65500, 65535)) :
                        16'($urandom_range(0, 239));
      pick = $urandom_range(0, 9);
      it.text_row = (pick == 0) ? 16'($urandom) :
                    (pick == 1) ? 16'($urandom_range(65520, 65535)) :
                    (pick == 2) ? 16'($urandom_range(225, 239)) : 16'($urandom_range(0, 232));
      it.fore_color = 16'($urandom);
      it.back_color = ($urandom_range(0, 9) < 3) ? it.fore_color : 16'($urandom);
      it.scale = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
      send_char(it);
    end
    in_valid_i <= 1'b0;

    while (sb.pending_rects.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.pending_rects.size() != 0) begin
      $error("%0d rectangles never arrived", sb.pending_rects.size());
    end
    if (sb.mismatches == 0 && sb.pending_rects.size() == 0) begin
      $display("scaled_font_glyph_renderer_top verification clean");
    end else begin
      $display("scaled_font_glyph_renderer_top verification failed");
    end
    $finish;
  end

endmodule
